### rtl/xml_element_text_extractor_macros.svh
// Assertion macros shared by the extractor modules.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef XML_ELEMENT_TEXT_EXTRACTOR_MACROS_SVH
`define XML_ELEMENT_TEXT_EXTRACTOR_MACROS_SVH

// property that must hold at every edge outside reset
`define XET_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define XET_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/xet_pkg.sv
// Shared types, constants and helper functions of the XML text extractor.
// No dependencies; used by every module of the block.
package xet_pkg;

  localparam int MAX_TAG_LEN = 8;
  localparam int CLOSE_MAX   = MAX_TAG_LEN + 3;  // "</" name ">"
  localparam int POS_W       = $clog2(CLOSE_MAX + 1);
  localparam int ENT_NUM     = 5;
  localparam int ENT_MAX     = 6;
  localparam int HOLD_DEPTH  = ENT_MAX - 1;
  localparam int HCNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int RES_MAX     = 16;
  localparam int RCNT_W      = $clog2(RES_MAX + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // entity spellings, padded with zero
  localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAX] = '{
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // &lt;
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // &gt;
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // &amp;
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // &quot;
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}    // &apos;
  };
  localparam logic [HCNT_W-1:0] ENT_LEN [ENT_NUM] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6};
  localparam logic [7:0] ENT_VAL [ENT_NUM] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  typedef enum logic [1:0] {
    CFG_TEXT_CHARS,
    CFG_TEXT_LEN,
    CFG_PARA_CHARS,
    CFG_PARA_LEN
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] text_chars;
    logic [3:0]  text_len;
    logic [63:0] para_chars;
    logic [3:0]  para_len;
  } cfg_t;

  // one command per accepted byte: feed prefix bytes of the close tag, then
  // optionally the byte itself, then flush held entity bytes, a newline, a clear
  typedef struct packed {
    logic [POS_W-1:0] feed_n;
    logic             feed_c;
    logic [7:0]       c;
    logic             flush;
    logic             newline;
    logic             clear;
  } cmd_t;

  function automatic logic [3:0] clamp_len(input logic [3:0] x);
    return (x > 4'(MAX_TAG_LEN)) ? 4'(MAX_TAG_LEN) : x;
  endfunction

  function automatic logic [7:0] name_char(input logic [63:0] chars, input logic [2:0] idx);
    logic [63:0] sh;
    sh = chars >> {idx, 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [7:0] close_char(input logic [POS_W-1:0] i,
                                            input logic [3:0] ttl,
                                            input logic [63:0] chars);
    logic [POS_W-1:0] k;
    k = i - POS_W'(2);
    if (i == '0) return CH_LT;
    else if (i == POS_W'(1)) return CH_SLASH;
    else if ({1'b0, i} < {1'b0, ttl} + 5'd2) return name_char(chars, k[2:0]);
    else return CH_GT;
  endfunction

endpackage

### rtl/xet_front.sv
// Front end: tag scanner and closing-tag matcher; turns each byte into one command.
// Depends on xet_pkg.
module xet_front (
  input  logic            clk,
  input  logic            rst,
  input  xet_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            doc_end,
  input  logic            q_full,
  output logic            q_push,
  output xet_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {S_OUT, S_TAG, S_TEXT} mode_t;

  mode_t                       mode, mode_next;
  logic [3:0]                  tcnt, tcnt_next;
  logic [1:0]                  flags, flags_next;
  logic [xet_pkg::POS_W-1:0]   cpos, cpos_next;

  logic [3:0]                  ttl, plen;
  logic [xet_pkg::POS_W-1:0]   lmax, pos, sel, pidx;
  logic [7:0]                  pat [xet_pkg::CLOSE_MAX];
  logic [xet_pkg::CLOSE_MAX-1:0] ok;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    ttl  = xet_pkg::clamp_len(cfg.text_len);
    plen = xet_pkg::clamp_len(cfg.para_len);
    for (int k = 0; k < xet_pkg::CLOSE_MAX; k++) begin
      pat[k] = xet_pkg::close_char(xet_pkg::POS_W'(k), ttl, cfg.text_chars);
    end
    lmax = xet_pkg::POS_W'(ttl) + xet_pkg::POS_W'(3);
    pos  = (cpos > lmax - xet_pkg::POS_W'(1)) ? lmax - xet_pkg::POS_W'(1) : cpos;

    // shortest shift that keeps a close-tag prefix after a mismatch
    ok = '0;
    for (int s = 1; s < xet_pkg::CLOSE_MAX; s++) begin
      pidx  = (xet_pkg::POS_W'(s) <= pos) ? pos - xet_pkg::POS_W'(s) : '0;
      ok[s] = (xet_pkg::POS_W'(s) <= pos) && (in_byte == pat[pidx]);
      for (int j = 0; j + s < xet_pkg::CLOSE_MAX; j++) begin
        if (xet_pkg::POS_W'(j + s) < pos && pat[j + s] != pat[j]) ok[s] = 1'b0;
      end
    end
    sel = pos + xet_pkg::POS_W'(1);
    for (int s = xet_pkg::CLOSE_MAX - 1; s >= 1; s--) begin
      if (ok[s]) sel = xet_pkg::POS_W'(s);
    end

    mode_next  = mode;
    tcnt_next  = tcnt;
    flags_next = flags;
    cpos_next  = cpos;
    cmd        = '0;
    cmd.c      = in_byte;

    case (mode)
      S_TAG: begin
        if (in_byte == xet_pkg::CH_GT) begin
          if (plen != 4'd0 && flags[1] && {1'b0, tcnt} >= {1'b0, plen} + 5'd1)
            cmd.newline = 1'b1;
          if (flags[0] && tcnt >= ttl) begin
            mode_next = S_TEXT;
            cpos_next = '0;
            cmd.clear = 1'b1;
          end else begin
            mode_next = S_OUT;
          end
          tcnt_next  = '0;
          flags_next = '0;
        end else begin
          if (tcnt < ttl) begin
            if (in_byte != xet_pkg::name_char(cfg.text_chars, tcnt[2:0])) flags_next[0] = 1'b0;
          end else if (tcnt == ttl) begin
            if (in_byte != xet_pkg::CH_SPACE) flags_next[0] = 1'b0;
          end
          if (tcnt == 4'd0) begin
            if (in_byte != xet_pkg::CH_SLASH) flags_next[1] = 1'b0;
          end else if (tcnt <= plen) begin
            if (in_byte != xet_pkg::name_char(cfg.para_chars, 3'(tcnt - 4'd1)))
              flags_next[1] = 1'b0;
          end
          if (tcnt != 4'd15) tcnt_next = tcnt + 4'd1;
        end
      end
      S_TEXT: begin
        if (in_byte == pat[pos]) begin
          if (pos + xet_pkg::POS_W'(1) == lmax) begin
            cmd.flush = 1'b1;
            mode_next = S_OUT;
            cpos_next = '0;
          end else begin
            cpos_next = pos + xet_pkg::POS_W'(1);
          end
        end else begin
          if (sel == pos + xet_pkg::POS_W'(1)) begin
            cmd.feed_n = pos;
            cmd.feed_c = 1'b1;
          end else begin
            cmd.feed_n = sel;
          end
          cpos_next = pos + xet_pkg::POS_W'(1) - sel;
        end
      end
      default: begin
        if (in_byte == xet_pkg::CH_LT) begin
          mode_next  = S_TAG;
          tcnt_next  = '0;
          flags_next = 2'b11;
        end else begin
          mode_next = S_OUT;
        end
      end
    endcase

    if (doc_end) begin
      mode_next  = S_OUT;
      tcnt_next  = '0;
      flags_next = '0;
      cpos_next  = '0;
      cmd.clear  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= S_OUT;
      tcnt  <= '0;
      flags <= '0;
      cpos  <= '0;
    end else if (q_push) begin
      mode  <= mode_next;
      tcnt  <= tcnt_next;
      flags <= flags_next;
      cpos  <= cpos_next;
    end
  end

endmodule

### rtl/xet_queue.sv
// Short command queue between the front end and the entity decoder.
// Depends on xet_pkg and the assertion macro header.
`include "xml_element_text_extractor_macros.svh"

module xet_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xet_pkg::cmd_t wdata,
  input  logic          pop,
  output xet_pkg::cmd_t head,
  output logic          valid,
  output logic          full
);

  xet_pkg::cmd_t              mem [xet_pkg::QDEPTH];
  logic [xet_pkg::QPTR_W-1:0] rptr, wptr;
  logic [xet_pkg::QCNT_W-1:0] count;

  assign head  = mem[rptr];
  assign valid = (count != '0);
  assign full  = (count == xet_pkg::QCNT_W'(xet_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + xet_pkg::QPTR_W'(1);
      if (pop)  rptr <= rptr + xet_pkg::QPTR_W'(1);
      count <= count + xet_pkg::QCNT_W'(push) - xet_pkg::QCNT_W'(pop);
    end
  end

  `XET_CHECK(a_q_count_range, count <= xet_pkg::QCNT_W'(xet_pkg::QDEPTH), "queue count overflow")
  `XET_CHECK_IMP(a_q_no_push_full, push, !full, "push into full queue")
  `XET_CHECK_IMP(a_q_no_pop_empty, pop, valid, "pop from empty queue")

endmodule

### rtl/xet_back.sv
// Back end: entity decoder, result cap, last-result marking and output register.
// Depends on xet_pkg and the assertion macro header.
`include "xml_element_text_extractor_macros.svh"

module xet_back (
  input  logic          clk,
  input  logic          rst,
  input  xet_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  xet_pkg::cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          run_last
);

  logic [7:0]                  hold [xet_pkg::HOLD_DEPTH];
  logic [7:0]                  hold_next [xet_pkg::HOLD_DEPTH];
  logic [xet_pkg::HCNT_W-1:0]  hcnt, hcnt_next;
  logic                        draining, draining_next;
  logic [xet_pkg::POS_W-1:0]   idx, idx_next, nfeed;
  logic                        nl_done, nl_done_next;
  logic [xet_pkg::RCNT_W-1:0]  item_cnt;
  logic                        pend_valid, pend_last;
  logic [7:0]                  pend_byte;

  logic                        can_push, step, emit, emit_ok, fin, any_m, complete;
  logic [7:0]                  b, ebyte;
  logic [3:0]                  ttl;
  logic [xet_pkg::ENT_NUM-1:0] m;
  logic [xet_pkg::HCNT_W-1:0]  mlen;
  logic [7:0]                  mval;

  assign can_push = !out_valid || out_ready;
  assign step     = q_valid && can_push;
  assign pop      = step && fin;
  assign emit_ok  = emit && (item_cnt < xet_pkg::RCNT_W'(xet_pkg::RES_MAX));

  always_comb begin
    ttl   = xet_pkg::clamp_len(cfg.text_len);
    nfeed = cmd.feed_n + xet_pkg::POS_W'(cmd.feed_c);
    b     = (idx < cmd.feed_n) ? xet_pkg::close_char(idx, ttl, cfg.text_chars) : cmd.c;

    // entity prefix match of held bytes plus b
    for (int e = 0; e < xet_pkg::ENT_NUM; e++) begin
      m[e] = (hcnt < xet_pkg::ENT_LEN[e]) && (b == xet_pkg::ENT_TEXT[e][hcnt]);
      for (int k = 0; k < xet_pkg::HOLD_DEPTH; k++) begin
        if (xet_pkg::HCNT_W'(k) < hcnt && hold[k] != xet_pkg::ENT_TEXT[e][k]) m[e] = 1'b0;
      end
    end
    any_m = |m;
    mlen  = '0;
    mval  = '0;
    for (int e = xet_pkg::ENT_NUM - 1; e >= 0; e--) begin
      if (m[e]) begin
        mlen = xet_pkg::ENT_LEN[e];
        mval = xet_pkg::ENT_VAL[e];
      end
    end
    complete = (hcnt + xet_pkg::HCNT_W'(1) == mlen);

    hold_next     = hold;
    hcnt_next     = hcnt;
    draining_next = draining;
    idx_next      = idx;
    nl_done_next  = nl_done;
    emit          = 1'b0;
    ebyte         = hold[0];

    if (idx < nfeed) begin
      if (draining || (hcnt != '0 && !any_m)) begin
        emit = 1'b1;
        for (int k = 0; k < xet_pkg::HOLD_DEPTH - 1; k++) hold_next[k] = hold[k + 1];
        hold_next[xet_pkg::HOLD_DEPTH - 1] = '0;
        hcnt_next     = hcnt - xet_pkg::HCNT_W'(1);
        draining_next = (hcnt > xet_pkg::HCNT_W'(1));
      end else if (hcnt == '0) begin
        if (b == xet_pkg::CH_AMP) begin
          hold_next[0] = b;
          hcnt_next    = xet_pkg::HCNT_W'(1);
        end else begin
          emit  = 1'b1;
          ebyte = b;
        end
        idx_next = idx + xet_pkg::POS_W'(1);
      end else begin
        if (complete) begin
          emit      = 1'b1;
          ebyte     = mval;
          hcnt_next = '0;
        end else begin
          hold_next[hcnt[2:0]] = b;
          hcnt_next            = hcnt + xet_pkg::HCNT_W'(1);
        end
        idx_next = idx + xet_pkg::POS_W'(1);
      end
    end else if (cmd.flush && hcnt != '0) begin
      emit = 1'b1;
      for (int k = 0; k < xet_pkg::HOLD_DEPTH - 1; k++) hold_next[k] = hold[k + 1];
      hold_next[xet_pkg::HOLD_DEPTH - 1] = '0;
      hcnt_next = hcnt - xet_pkg::HCNT_W'(1);
    end else if (cmd.newline && !nl_done) begin
      emit         = 1'b1;
      ebyte        = xet_pkg::CH_NL;
      nl_done_next = 1'b1;
    end

    fin = !((idx_next < nfeed) || (cmd.flush && hcnt_next != '0) ||
            (cmd.newline && !nl_done_next));
    if (fin) begin
      idx_next      = '0;
      nl_done_next  = 1'b0;
      draining_next = 1'b0;
      if (cmd.clear) hcnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt       <= '0;
      draining   <= 1'b0;
      idx        <= '0;
      nl_done    <= 1'b0;
      item_cnt   <= '0;
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (step) begin
        hold     <= hold_next;
        hcnt     <= hcnt_next;
        draining <= draining_next;
        idx      <= idx_next;
        nl_done  <= nl_done_next;
        if (fin) item_cnt <= '0;
        else if (emit_ok) item_cnt <= item_cnt + xet_pkg::RCNT_W'(1);
      end

      if (step && emit_ok) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_byte  <= pend_byte;
          run_last  <= pend_last;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_byte  <= ebyte;
        pend_last  <= fin;
      end else if (pend_valid && (pend_last || (step && fin)) && can_push) begin
        out_valid  <= 1'b1;
        out_byte   <= pend_byte;
        run_last   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `XET_CHECK(a_hold_range, hcnt <= xet_pkg::HCNT_W'(xet_pkg::HOLD_DEPTH), "entity hold overflow")
  `XET_CHECK_IMP(a_drain_has_data, draining, hcnt != '0, "draining with empty hold")
  `XET_CHECK(a_result_cap, item_cnt <= xet_pkg::RCNT_W'(xet_pkg::RES_MAX), "result cap exceeded")

endmodule

### rtl/xml_element_text_extractor.sv
// XML element text extractor, top level: configuration registers, front end,
// command queue and entity-decoding back end. Depends on xet_pkg and submodules.
//
// Usage:
//   Document bytes enter on in_valid/in_ready with in_byte and doc_end (set on
//   the last byte of a document). Each request yields zero or more result bytes
//   on out_valid/out_ready: out_byte carries text (entities decoded) or a newline
//   for a paragraph close; run_last marks the final result of one input byte.
//   Registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
//   and cfg_data, by the user only while the block is idle (not enforced).
// Data path and throughput:
//   Results pass the queue, a pending register and the output register. When
//   not stalled, the decoder takes one step per cycle: one per byte it decodes
//   (held close-tag bytes plus the byte itself), one per held entity byte
//   released, one for a newline, at least one per request; plain bytes stream
//   at one per cycle. A four-entry command queue lets input flow while it works.
// Reset: synchronous rst clears scan state, queue, held entity and output; the
//   name registers return to "w:t" text and "w:p" paragraph defaults.
// Stall: while out_valid is high and out_ready low, the output register and the
//   decoder hold; the queue fills and in_ready drops once full. Nothing is lost.
module xml_element_text_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        doc_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  xet_pkg::cfg_t cfg;
  xet_pkg::cmd_t f_cmd, q_head;
  logic          q_push, q_full, q_valid, q_pop;

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_chars <= 64'd7617143;
      cfg.text_len   <= 4'd3;
      cfg.para_chars <= 64'd7354999;
      cfg.para_len   <= 4'd3;
    end else if (cfg_valid) begin
      case (xet_pkg::cfg_idx_t'(cfg_index))
        xet_pkg::CFG_TEXT_CHARS: cfg.text_chars <= cfg_data;
        xet_pkg::CFG_TEXT_LEN:   cfg.text_len   <= cfg_data[3:0];
        xet_pkg::CFG_PARA_CHARS: cfg.para_chars <= cfg_data;
        xet_pkg::CFG_PARA_LEN:   cfg.para_len   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // front: tag scan and close-tag match, one command per request
  xet_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .doc_end  (doc_end),
    .q_full   (q_full),
    .q_push   (q_push),
    .cmd      (f_cmd)
  );

  xet_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (f_cmd),
    .pop   (q_pop),
    .head  (q_head),
    .valid (q_valid),
    .full  (q_full)
  );

  // back: entity decode, result cap, run_last, output register
  xet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .cmd       (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule
